@@ hw/rtl/amc_pkg.sv @@
// Shared types and codes of the accumulator machine core.
package amc_pkg;

    localparam int MEM_DEPTH  = 256;
    localparam int ADDR_BITS  = 8;
    localparam int WORD_BITS  = 32;
    localparam int PC_BITS    = 9;

    // Item operations
    localparam logic [1:0] OPER_WRITE   = 2'd0;
    localparam logic [1:0] OPER_STEP    = 2'd1;
    localparam logic [1:0] OPER_RESTART = 2'd2;
    localparam logic [1:0] OPER_NOP     = 2'd3;

    // Instruction codes
    localparam logic [3:0] OPC_NONE    = 4'd0;
    localparam logic [3:0] OPC_ADD     = 4'd1;
    localparam logic [3:0] OPC_SUB     = 4'd2;
    localparam logic [3:0] OPC_MULT    = 4'd3;
    localparam logic [3:0] OPC_DIV     = 4'd4;
    localparam logic [3:0] OPC_JMP     = 4'd5;
    localparam logic [3:0] OPC_JMPN    = 4'd6;
    localparam logic [3:0] OPC_JMPP    = 4'd7;
    localparam logic [3:0] OPC_JMPZ    = 4'd8;
    localparam logic [3:0] OPC_COPY    = 4'd9;
    localparam logic [3:0] OPC_LOAD    = 4'd10;
    localparam logic [3:0] OPC_STORE   = 4'd11;
    localparam logic [3:0] OPC_INPUT   = 4'd12;
    localparam logic [3:0] OPC_OUTPUT  = 4'd13;
    localparam logic [3:0] OPC_STOP    = 4'd14;
    localparam logic [3:0] OPC_UNKNOWN = 4'd15;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_STOP     = 3'd1;
    localparam logic [2:0] STS_PAST_END = 3'd2;
    localparam logic [2:0] STS_DIV_ZERO = 3'd3;
    localparam logic [2:0] STS_BAD_ADDR = 3'd4;
    localparam logic [2:0] STS_HALTED   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPND1,
        ST_OPND2,
        ST_DATA,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } t_state;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [2:0]           status;
        logic                 input_taken;
        logic [WORD_BITS-1:0] out_value;
        logic                 out_valid;
        logic [WORD_BITS-1:0] acc_after;
        logic [PC_BITS-1:0]   pc_after;
        logic [3:0]           opcode_done;
    } t_result;

endpackage

@@ hw/rtl/amc_div.sv @@
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module amc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [amc_pkg::WORD_BITS-1:0] i_dividend,
    input  logic [amc_pkg::WORD_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [amc_pkg::WORD_BITS-1:0] o_quotient
);
    localparam int CNT_BITS = $clog2(amc_pkg::WORD_BITS) + 1;

    logic [amc_pkg::WORD_BITS:0]   r_rem, n_rem;
    logic [amc_pkg::WORD_BITS-1:0] r_quo, n_quo;
    logic [amc_pkg::WORD_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0]           r_cnt, n_cnt;
    logic                          r_busy, n_busy, r_done, n_done;
    logic [amc_pkg::WORD_BITS:0]   w_shift, w_diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        w_shift = {r_rem[amc_pkg::WORD_BITS-1:0], r_quo[amc_pkg::WORD_BITS-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CNT_BITS'(amc_pkg::WORD_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[amc_pkg::WORD_BITS]) begin
                n_rem = w_diff;
                n_quo = {r_quo[amc_pkg::WORD_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[amc_pkg::WORD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hw/rtl/accumulator_machine_core.sv @@
// Top level of the accumulator machine core.
//
// Slave channel (s_axis): one beat per item; operation selects a memory word
// write, one instruction step, or a restart of pc and accumulator.
// Master channel (m_axis): exactly one result beat per item, carrying the
// opcode done, pc and accumulator after the step, any OUTPUT word, the
// INPUT flag and a status code.
// Config channel: writes program_length; change it only while idle.
// A step needs up to four dependent reads (opcode, two operands, data
// word) of the single-port word memory, each a registered read. MULT adds
// the ST_MULT state; DIV waits in ST_DIV for the one-bit-per-cycle divider.
// One item is worked on at a time; the next is accepted while a finished
// result still waits in the output register.
// Reset clears pc, accumulator, halt flag and program_length; memory
// contents stay undefined until written. A stalled receiver holds the
// result beat; once the next item is finished the core waits for it.
module accumulator_machine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation[1:0], address[9:2], data[41:10]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode_done[3:0], pc_after[12:4], acc_after[44:13], out_valid[45],
    // out_value[77:46], input_taken[78], status[81:79]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready
);
    localparam int WB = amc_pkg::WORD_BITS;
    localparam int PB = amc_pkg::PC_BITS;
    localparam int AB = amc_pkg::ADDR_BITS;

    amc_pkg::t_state  r_state, n_state;
    amc_pkg::t_result r_res, n_res, r_out;
    logic             r_ovalid;

    logic [PB-1:0] r_plen;
    logic [PB-1:0] r_pc, n_pc;
    logic [WB-1:0] r_acc, n_acc;
    logic          r_halt, n_halt;
    logic [3:0]    r_code, n_code;
    logic [PB-1:0] r_npc, n_npc;
    logic [WB-1:0] r_a1, n_a1;
    logic [AB-1:0] r_a2, n_a2;
    logic [WB-1:0] r_data, n_data;
    logic [WB-1:0] r_prod, n_prod;
    logic          r_negq, n_negq;

    // Word memory
    logic [WB-1:0] r_mem [amc_pkg::MEM_DEPTH];
    logic [WB-1:0] r_rdata;
    logic          w_we;
    logic [AB-1:0] w_addr;
    logic [WB-1:0] w_wdata;

    // Divider
    logic          w_div_start, w_div_done;
    logic [WB-1:0] w_quo, w_dvd_mag, w_dvs_mag;

    logic          w_accept, w_out_free;
    logic [1:0]    w_oper;
    logic [PB-1:0] w_lim;
    logic [PB:0]   w_end;
    logic [PB-1:0] w_len;
    logic [3:0]    w_code;
    logic          w_take, w_a1_ok, w_a2_ok, w_tgt_ok;
    logic [WB-1:0] w_qs;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_oper     = s_axis_tdata[1:0];
    assign w_lim      = (r_plen < PB'(amc_pkg::MEM_DEPTH)) ? r_plen : PB'(amc_pkg::MEM_DEPTH);
    assign w_dvd_mag  = r_acc[WB-1] ? (WB'(0) - r_acc) : r_acc;
    assign w_dvs_mag  = r_rdata[WB-1] ? (WB'(0) - r_rdata) : r_rdata;
    assign w_qs       = r_negq ? (WB'(0) - w_quo) : w_quo;

    // Decode fetched word and operand checks
    always_comb begin
        w_code = (!r_rdata[WB-1] && r_rdata < WB'(15)) ? r_rdata[3:0] : amc_pkg::OPC_NONE;
        case (w_code)
            amc_pkg::OPC_STOP: w_len = PB'(1);
            amc_pkg::OPC_COPY: w_len = PB'(3);
            default:           w_len = PB'(2);
        endcase
        w_end    = {1'b0, r_pc} + {1'b0, w_len};
        w_a1_ok  = !r_rdata[WB-1] && r_rdata < WB'(w_lim);
        w_tgt_ok = !r_rdata[WB-1] && r_rdata <= WB'(w_lim);
        w_a2_ok  = !r_rdata[WB-1] && r_rdata < WB'(w_lim);
        case (r_code)
            amc_pkg::OPC_JMP:  w_take = 1'b1;
            amc_pkg::OPC_JMPN: w_take = r_acc[WB-1];
            amc_pkg::OPC_JMPP: w_take = !r_acc[WB-1] && (r_acc != '0);
            amc_pkg::OPC_JMPZ: w_take = (r_acc == '0);
            default:           w_take = 1'b0;
        endcase
    end

    // Sequencer: next state, memory port and result
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_halt  = r_halt;
        n_code  = r_code;
        n_npc   = r_npc;
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_data  = r_data;
        n_prod  = r_prod;
        n_negq  = r_negq;
        w_we    = 1'b0;
        w_addr  = r_pc[AB-1:0];
        w_wdata = r_data;
        w_div_start   = 1'b0;
        s_axis_tready = (r_state == amc_pkg::ST_IDLE);
        case (r_state)
            amc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_data = s_axis_tdata[41:10];
                    n_res  = '0;
                    n_state = amc_pkg::ST_DONE;
                    case (w_oper)
                        amc_pkg::OPER_WRITE: begin
                            w_we    = 1'b1;
                            w_addr  = s_axis_tdata[9:2];
                            w_wdata = s_axis_tdata[41:10];
                        end
                        amc_pkg::OPER_RESTART: begin
                            n_pc   = '0;
                            n_acc  = '0;
                            n_halt = 1'b0;
                        end
                        amc_pkg::OPER_STEP: begin
                            if (r_halt) begin
                                n_res.status = amc_pkg::STS_HALTED;
                            end else if (r_pc >= w_lim) begin
                                n_res.status = amc_pkg::STS_PAST_END;
                            end else begin
                                n_state = amc_pkg::ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                    n_res.pc_after  = n_pc;
                    n_res.acc_after = n_acc;
                end
            end
            amc_pkg::ST_FETCH: begin
                n_code  = w_code;
                n_npc   = w_end[PB-1:0];
                n_state = amc_pkg::ST_DONE;
                if (w_code == amc_pkg::OPC_NONE) begin
                    n_pc = r_pc + 1'b1;
                    n_res.opcode_done = amc_pkg::OPC_UNKNOWN;
                end else if (w_end > {1'b0, w_lim}) begin
                    n_res.status = amc_pkg::STS_BAD_ADDR;
                end else if (w_code == amc_pkg::OPC_STOP) begin
                    n_halt = 1'b1;
                    n_res.opcode_done = amc_pkg::OPC_STOP;
                    n_res.status = amc_pkg::STS_STOP;
                end else begin
                    w_addr  = r_pc[AB-1:0] + AB'(1);
                    n_state = amc_pkg::ST_OPND1;
                end
                n_res.pc_after = n_pc;
            end
            amc_pkg::ST_OPND1: begin
                n_a1    = r_rdata;
                n_state = amc_pkg::ST_DONE;
                if (r_code >= amc_pkg::OPC_JMP && r_code <= amc_pkg::OPC_JMPZ) begin
                    if (w_take && !w_tgt_ok) begin
                        n_res.status = amc_pkg::STS_BAD_ADDR;
                    end else begin
                        if (w_take) begin
                            n_pc = r_rdata[PB-1:0];
                        end else begin
                            n_pc = r_npc;
                        end
                        n_res.opcode_done = r_code;
                    end
                end else if (!w_a1_ok) begin
                    n_res.status = amc_pkg::STS_BAD_ADDR;
                end else if (r_code == amc_pkg::OPC_COPY) begin
                    w_addr  = r_pc[AB-1:0] + AB'(2);
                    n_state = amc_pkg::ST_OPND2;
                end else begin
                    w_addr  = r_rdata[AB-1:0];
                    n_state = amc_pkg::ST_DATA;
                end
                n_res.pc_after = n_pc;
            end
            amc_pkg::ST_OPND2: begin
                n_a2 = r_rdata[AB-1:0];
                if (!w_a2_ok) begin
                    n_res.status = amc_pkg::STS_BAD_ADDR;
                    n_state = amc_pkg::ST_DONE;
                end else begin
                    w_addr  = r_a1[AB-1:0];
                    n_state = amc_pkg::ST_DATA;
                end
            end
            amc_pkg::ST_DATA: begin
                n_state = amc_pkg::ST_DONE;
                n_res.opcode_done = r_code;
                n_pc = r_npc;
                case (r_code)
                    amc_pkg::OPC_ADD:  n_acc = r_acc + r_rdata;
                    amc_pkg::OPC_SUB:  n_acc = r_acc - r_rdata;
                    amc_pkg::OPC_LOAD: n_acc = r_rdata;
                    amc_pkg::OPC_MULT: begin
                        n_prod  = WB'(r_acc * r_rdata);
                        n_pc    = r_pc;
                        n_state = amc_pkg::ST_MULT;
                    end
                    amc_pkg::OPC_DIV: begin
                        n_pc = r_pc;
                        if (r_rdata == '0) begin
                            n_res.opcode_done = amc_pkg::OPC_NONE;
                            n_res.status = amc_pkg::STS_DIV_ZERO;
                        end else begin
                            w_div_start = 1'b1;
                            n_negq  = r_acc[WB-1] ^ r_rdata[WB-1];
                            n_state = amc_pkg::ST_DIV;
                        end
                    end
                    amc_pkg::OPC_COPY: begin
                        w_we    = 1'b1;
                        w_addr  = r_a2;
                        w_wdata = r_rdata;
                    end
                    amc_pkg::OPC_STORE: begin
                        w_we    = 1'b1;
                        w_addr  = r_a1[AB-1:0];
                        w_wdata = r_acc;
                    end
                    amc_pkg::OPC_INPUT: begin
                        w_we    = 1'b1;
                        w_addr  = r_a1[AB-1:0];
                        w_wdata = r_data;
                        n_res.input_taken = 1'b1;
                    end
                    amc_pkg::OPC_OUTPUT: begin
                        n_res.out_valid = 1'b1;
                        n_res.out_value = r_rdata;
                    end
                    default: ;
                endcase
                n_res.pc_after  = n_pc;
                n_res.acc_after = n_acc;
            end
            amc_pkg::ST_MULT: begin
                n_acc = r_prod;
                n_pc  = r_npc;
                n_res.pc_after  = n_pc;
                n_res.acc_after = n_acc;
                n_state = amc_pkg::ST_DONE;
            end
            amc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_acc = w_qs;
                    n_pc  = r_npc;
                    n_res.pc_after  = n_pc;
                    n_res.acc_after = n_acc;
                    n_state = amc_pkg::ST_DONE;
                end
            end
            amc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = amc_pkg::ST_IDLE;
                end
            end
            default: n_state = amc_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= amc_pkg::ST_IDLE;
            r_pc     <= '0;
            r_acc    <= '0;
            r_halt   <= 1'b0;
            r_plen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
            if (i_cfg_valid) begin
                r_plen <= i_cfg_data;
            end
            if (r_state == amc_pkg::ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_code <= n_code;
        r_npc  <= n_npc;
        r_a1   <= n_a1;
        r_a2   <= n_a2;
        r_data <= n_data;
        r_prod <= n_prod;
        r_negq <= n_negq;
        if (r_state == amc_pkg::ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    // Single-port memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    amc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_mag),
        .i_divisor  (w_dvs_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign m_axis_tdata  = {6'b0, r_out};
    assign m_axis_tvalid = r_ovalid;
    assign o_cfg_ready   = 1'b1;

endmodule

@@ hw/rtl/amc_checker.sv @@
// Port-level checks of the accumulator machine core, bound to the top level.
module amc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);
    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // No result straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat shown after reset");

    // Status code stays in its range
    a_sts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[81:79] <= amc_pkg::STS_HALTED)
        else $error("status out of range");

    // No output word without out_valid
    a_oval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[45] |-> m_axis_tdata[77:46] == '0)
        else $error("out_value set without out_valid");

    // Failed steps report no opcode
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[81:79] >= amc_pkg::STS_PAST_END |->
        m_axis_tdata[3:0] == amc_pkg::OPC_NONE)
        else $error("opcode reported on failed step");

endmodule

bind accumulator_machine_core amc_checker u_amc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

@@ tb/sv/tb_accumulator_machine_core.sv @@
// Testbench for the accumulator machine core: random programs, beat-level checking.
`timescale 1ns / 100ps

module tb_accumulator_machine_core;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  addr;
        logic [31:0] dat;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;

    // Machine state as predicted
    logic [31:0] mem_img [amc_pkg::MEM_DEPTH];
    logic [8:0]  pc_img = '0;
    logic [31:0] acc_img = '0;
    logic        halt_img = 1'b0;
    logic [8:0]  length_img = '0;

    t_item            pending_items [$];
    amc_pkg::t_result expected_results [$];
    int      errors = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_mode = 0;
    int      cycle_cnt = 0;
    int      results_seen = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    int      quiet_cycles = 0;

    accumulator_machine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_data    (i_cfg_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // Apply one item to the predicted machine and queue its result
    task automatic execute_item(input t_item it);
        amc_pkg::t_result r;
        int          lim, pc, code, len, npc;
        logic [31:0] w, a1, a2, acc, v, ma, mv, q;
        logic        bad, div0, take;
        r = '0;
        if (it.op == amc_pkg::OPER_WRITE) begin
            mem_img[it.addr] = it.dat;
        end else if (it.op == amc_pkg::OPER_RESTART) begin
            pc_img = '0;
            acc_img = '0;
            halt_img = 1'b0;
        end else if (it.op == amc_pkg::OPER_STEP) begin
            lim = (length_img < amc_pkg::MEM_DEPTH) ? int'(length_img) : amc_pkg::MEM_DEPTH;
            pc = int'(pc_img);
            if (halt_img) begin
                r.status = amc_pkg::STS_HALTED;
            end else if (pc >= lim) begin
                r.status = amc_pkg::STS_PAST_END;
            end else begin
                w = mem_img[pc];
                code = (!w[31] && int'(w) < 15) ? int'(w) : 0;
                len = (code == 0 || code == amc_pkg::OPC_STOP) ? 1 :
                      (code == amc_pkg::OPC_COPY) ? 3 : 2;
                if (code == 0) begin
                    pc_img = 9'(pc + 1);
                    r.opcode_done = amc_pkg::OPC_UNKNOWN;
                end else if (pc + len > lim) begin
                    r.status = amc_pkg::STS_BAD_ADDR;
                end else if (code == amc_pkg::OPC_STOP) begin
                    halt_img = 1'b1;
                    r.opcode_done = amc_pkg::OPC_STOP;
                    r.status = amc_pkg::STS_STOP;
                end else begin
                    a1 = mem_img[pc + 1];
                    a2 = (len == 3) ? mem_img[pc + 2] : '0;
                    bad = 1'b0;
                    div0 = 1'b0;
                    acc = acc_img;
                    npc = pc + len;
                    if (code >= amc_pkg::OPC_JMP && code <= amc_pkg::OPC_JMPZ) begin
                        take = (code == amc_pkg::OPC_JMP) ||
                               (code == amc_pkg::OPC_JMPN && acc[31]) ||
                               (code == amc_pkg::OPC_JMPP && !acc[31] && acc != 0) ||
                               (code == amc_pkg::OPC_JMPZ && acc == 0);
                        if (take) begin
                            if (!a1[31] && int'(a1) <= lim) npc = int'(a1);
                            else bad = 1'b1;
                        end
                    end else if (a1[31] || int'(a1) >= lim ||
                                 (code == amc_pkg::OPC_COPY && (a2[31] || int'(a2) >= lim))) begin
                        bad = 1'b1;
                    end else begin
                        v = mem_img[a1];
                        case (code)
                            amc_pkg::OPC_ADD:  acc = acc + v;
                            amc_pkg::OPC_SUB:  acc = acc - v;
                            amc_pkg::OPC_MULT: acc = acc * v;
                            amc_pkg::OPC_DIV: begin
                                if (v == 0) begin
                                    div0 = 1'b1;
                                end else begin
                                    ma = acc[31] ? -acc : acc;
                                    mv = v[31] ? -v : v;
                                    q = ma / mv;
                                    acc = (acc[31] != v[31]) ? -q : q;
                                end
                            end
                            amc_pkg::OPC_LOAD: acc = v;
                            default: ;
                        endcase
                        if (!div0) begin
                            if (code == amc_pkg::OPC_COPY) mem_img[a2] = v;
                            else if (code == amc_pkg::OPC_STORE) mem_img[a1] = acc;
                            else if (code == amc_pkg::OPC_INPUT) begin
                                mem_img[a1] = it.dat;
                                r.input_taken = 1'b1;
                            end else if (code == amc_pkg::OPC_OUTPUT) begin
                                r.out_valid = 1'b1;
                                r.out_value = v;
                            end
                        end
                    end
                    if (bad) begin
                        r = '0;
                        r.status = amc_pkg::STS_BAD_ADDR;
                    end else if (div0) begin
                        r.status = amc_pkg::STS_DIV_ZERO;
                    end else begin
                        acc_img = acc;
                        pc_img = 9'(npc);
                        r.opcode_done = 4'(code);
                    end
                end
            end
        end
        r.pc_after = pc_img;
        r.acc_after = acc_img;
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endfunction

    // Drive input beats in bursts separated by random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                execute_item('{s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tdata[41:10]});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_item nx;
                    nx = pending_items.pop_front();
                    s_axis_tdata <= {6'b0, nx.dat, nx.addr, nx.op};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check result beats and stall the receiver on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                amc_pkg::t_result act, exp_r;
                act = amc_pkg::t_result'(m_axis_tdata[81:0]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, act);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("opcode_done", exp_r.opcode_done, act.opcode_done);
                    check_field("pc_after", exp_r.pc_after, act.pc_after);
                    check_field("acc_after", exp_r.acc_after, act.acc_after);
                    check_field("out_valid", exp_r.out_valid, act.out_valid);
                    check_field("out_value", exp_r.out_value, act.out_value);
                    check_field("input_taken", exp_r.input_taken, act.input_taken);
                    check_field("status", exp_r.status, act.status);
                end
            end
            cycle_cnt++;
            if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
            if (!hold_done && results_seen >= 350) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_mode == 0) begin
                m_axis_tready <= 1'b1;
            end else if (stall_mode == 1) begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end else begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 3000) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [7:0] addr,
                            input logic [31:0] dat);
        t_item it;
        it = '{op, addr, dat};
        pending_items.insert(pending_items.size(), it);
    endtask

    // Hold until every beat is sent and answered, then let the core settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [8:0] len);
        @(posedge i_clk);
        i_cfg_data <= len;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        length_img = len;
    endtask

    // Mix of opcodes, addresses around the limit and odd data words
    function automatic logic [31:0] program_word(input int lim);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 32'($urandom_range(1, 14));
        if (sel < 78) return 32'($urandom_range(0, lim));
        if (sel < 88) return 32'($urandom_range(0, 20)) - 32'd10;
        if (sel < 94) return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            4: return 32'd15;
            default: return 32'd16;
        endcase
    endfunction

    task automatic random_phase(input int lim, input int first_word, input int n_items);
        int sel, a;
        add_item(amc_pkg::OPER_RESTART, 8'($urandom), $urandom);
        for (int i = first_word; i < lim; i++) add_item(amc_pkg::OPER_WRITE, 8'(i), program_word(lim));
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                add_item(amc_pkg::OPER_STEP, 8'($urandom), $urandom);
            end else if (sel < 85) begin
                add_item(amc_pkg::OPER_RESTART, 8'($urandom), $urandom);
            end else if (sel < 97) begin
                a = $urandom_range(0, 255);
                add_item(amc_pkg::OPER_WRITE, 8'(a), (a < lim) ? program_word(lim) : $urandom);
            end else begin
                add_item(amc_pkg::OPER_NOP, 8'($urandom), $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin
        int lengths [6];
        int starts [6];
        lengths = '{0, 1, 3, 24, 255, 256};
        // Words below each start are already written by earlier phases
        starts = '{0, 0, 0, 0, 24, 255};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: divide overflow, output, input, branch not taken, stop, halt
        write_length(9'd16);
        add_item(amc_pkg::OPER_WRITE, 8'd0, 32'(amc_pkg::OPC_LOAD));
        add_item(amc_pkg::OPER_WRITE, 8'd1, 32'd14);
        add_item(amc_pkg::OPER_WRITE, 8'd2, 32'(amc_pkg::OPC_DIV));
        add_item(amc_pkg::OPER_WRITE, 8'd3, 32'd15);
        add_item(amc_pkg::OPER_WRITE, 8'd4, 32'(amc_pkg::OPC_OUTPUT));
        add_item(amc_pkg::OPER_WRITE, 8'd5, 32'd14);
        add_item(amc_pkg::OPER_WRITE, 8'd6, 32'(amc_pkg::OPC_INPUT));
        add_item(amc_pkg::OPER_WRITE, 8'd7, 32'd12);
        add_item(amc_pkg::OPER_WRITE, 8'd8, 32'(amc_pkg::OPC_JMPZ));
        add_item(amc_pkg::OPER_WRITE, 8'd9, 32'd13);
        add_item(amc_pkg::OPER_WRITE, 8'd10, 32'(amc_pkg::OPC_STOP));
        add_item(amc_pkg::OPER_WRITE, 8'd11, 32'd99);
        add_item(amc_pkg::OPER_WRITE, 8'd12, 32'd0);
        add_item(amc_pkg::OPER_WRITE, 8'd13, 32'd0);
        add_item(amc_pkg::OPER_WRITE, 8'd14, 32'h8000_0000);
        add_item(amc_pkg::OPER_WRITE, 8'd255, 32'hFFFF_FFFF);
        add_item(amc_pkg::OPER_WRITE, 8'd15, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++) add_item(amc_pkg::OPER_STEP, 8'hFF, 32'h7FFF_FFFF);
        add_item(amc_pkg::OPER_RESTART, 8'h00, 32'h0);
        add_item(amc_pkg::OPER_NOP, 8'hAA, 32'h5555_5555);
        // Negative word as opcode, then divide by zero, then jump beyond the limit
        add_item(amc_pkg::OPER_WRITE, 8'd0, 32'hFFFF_FFFB);
        add_item(amc_pkg::OPER_STEP, 8'h00, 32'h0);
        add_item(amc_pkg::OPER_RESTART, 8'h00, 32'h0);
        add_item(amc_pkg::OPER_WRITE, 8'd0, 32'(amc_pkg::OPC_DIV));
        add_item(amc_pkg::OPER_WRITE, 8'd1, 32'd13);
        add_item(amc_pkg::OPER_STEP, 8'h00, 32'h0);
        add_item(amc_pkg::OPER_WRITE, 8'd0, 32'(amc_pkg::OPC_JMP));
        add_item(amc_pkg::OPER_WRITE, 8'd1, 32'd17);
        add_item(amc_pkg::OPER_STEP, 8'h00, 32'h0);
        wait_idle();

        // Random phases over a range of program lengths
        foreach (lengths[k]) begin
            write_length(9'(lengths[k]));
            random_phase(lengths[k], starts[k], (lengths[k] == 0) ? 10 : 30);
        end

        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/amc_pkg.sv
hw/rtl/amc_div.sv
hw/rtl/accumulator_machine_core.sv
hw/rtl/amc_checker.sv
tb/sv/tb_accumulator_machine_core.sv
